### rtl/cbmc_pkg.sv
// Shared types, register map and inverse table for the chained byte multiply cipher.
package cbmc_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_MODE_DECRYPT = 2'd0;
  localparam logic [1:0] REG_START_KEY    = 2'd1;
  localparam logic [1:0] REG_OFFSET_ALPHA = 2'd2;

  localparam logic       MODE_DECRYPT_RESET = 1'b0;
  localparam logic [7:0] START_KEY_RESET    = 8'd1;
  localparam logic [7:0] OFFSET_ALPHA_RESET = 8'd0;

  typedef struct packed {
    logic       mode_decrypt;
    logic [7:0] start_key;
    logic [7:0] offset_alpha;
  } cfg_t;

  // inverse modulo 256 of each odd byte 2*i+1
  localparam logic [7:0] ODD_INV [128] = '{
    8'd1,   8'd171, 8'd205, 8'd183, 8'd57,  8'd163, 8'd197, 8'd239,
    8'd241, 8'd27,  8'd61,  8'd167, 8'd41,  8'd19,  8'd53,  8'd223,
    8'd225, 8'd139, 8'd173, 8'd151, 8'd25,  8'd131, 8'd165, 8'd207,
    8'd209, 8'd251, 8'd29,  8'd135, 8'd9,   8'd243, 8'd21,  8'd191,
    8'd193, 8'd107, 8'd141, 8'd119, 8'd249, 8'd99,  8'd133, 8'd175,
    8'd177, 8'd219, 8'd253, 8'd103, 8'd233, 8'd211, 8'd245, 8'd159,
    8'd161, 8'd75,  8'd109, 8'd87,  8'd217, 8'd67,  8'd101, 8'd143,
    8'd145, 8'd187, 8'd221, 8'd71,  8'd201, 8'd179, 8'd213, 8'd127,
    8'd129, 8'd43,  8'd77,  8'd55,  8'd185, 8'd35,  8'd69,  8'd111,
    8'd113, 8'd155, 8'd189, 8'd39,  8'd169, 8'd147, 8'd181, 8'd95,
    8'd97,  8'd11,  8'd45,  8'd23,  8'd153, 8'd3,   8'd37,  8'd79,
    8'd81,  8'd123, 8'd157, 8'd7,   8'd137, 8'd115, 8'd149, 8'd63,
    8'd65,  8'd235, 8'd13,  8'd247, 8'd121, 8'd227, 8'd5,   8'd47,
    8'd49,  8'd91,  8'd125, 8'd231, 8'd105, 8'd83,  8'd117, 8'd31,
    8'd33,  8'd203, 8'd237, 8'd215, 8'd89,  8'd195, 8'd229, 8'd15,
    8'd17,  8'd59,  8'd93,  8'd199, 8'd73,  8'd51,  8'd85,  8'd255
  };

endpackage

### rtl/chained_byte_multiply_cipher.sv
// Top level: each accepted byte passes through the input hold register, then the result register.
// Throughput: one byte per cycle unless out_stall holds the result register; an 8x8
// multiply (by a table inverse when encrypting) sits between the hold and result registers.
// Reset (synchronous, rst high): empties both stages, chain key to 1,
// mode to encrypt, start key to 1, offset to 0.
module chained_byte_multiply_cipher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbmc_pkg::DATA_W-1:0]  pwdata,
  output logic [cbmc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   data_byte,
  input  logic                         first_byte,
  input  logic                         last_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic [7:0]                   next_key,
  output logic                         out_last
);
  import cbmc_pkg::*;

  cfg_t cfg;

  cbmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbmc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .next_key   (next_key),
    .out_last   (out_last)
  );

endmodule

### rtl/cbmc_regs.sv
// APB configuration registers: mode, start key and offset.
module cbmc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cbmc_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbmc_pkg::DATA_W-1:0]  pwdata,
  output logic [cbmc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output cbmc_pkg::cfg_t               cfg
);
  import cbmc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_decrypt <= MODE_DECRYPT_RESET;
      cfg.start_key    <= START_KEY_RESET;
      cfg.offset_alpha <= OFFSET_ALPHA_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_MODE_DECRYPT: cfg.mode_decrypt <= pwdata[0];
        REG_START_KEY:    cfg.start_key    <= pwdata[7:0];
        REG_OFFSET_ALPHA: cfg.offset_alpha <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MODE_DECRYPT: prdata = {{(DATA_W-1){1'b0}}, cfg.mode_decrypt};
      REG_START_KEY:    prdata = {{(DATA_W-8){1'b0}}, cfg.start_key};
      REG_OFFSET_ALPHA: prdata = {{(DATA_W-8){1'b0}}, cfg.offset_alpha};
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/cbmc_datapath.sv
// Input register, chained key, byte transform and result register.
module cbmc_datapath (
  input  logic           clk,
  input  logic           rst,
  input  cbmc_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           first_byte,
  input  logic           last_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic [7:0]     next_key,
  output logic           out_last
);
  import cbmc_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_data;
  logic       hold_first;
  logic       hold_last;
  logic [7:0] chain_key;

  logic       out_free;
  logic       advance;
  logic [7:0] key;
  logic [7:0] diff;
  logic [7:0] plain;
  logic [7:0] cipher;
  logic [7:0] result;
  logic [7:0] chain_key_next;

  assign out_free = ~out_valid | ~out_stall;
  assign advance  = hold_valid & out_free;
  assign in_stall = hold_valid & ~out_free;

  assign key    = hold_first ? cfg.start_key : chain_key;
  assign diff   = hold_data - cfg.offset_alpha;
  assign cipher = cfg.offset_alpha + 8'(hold_data * ODD_INV[key[7:1]]);

  always_comb begin
    if (cfg.mode_decrypt) begin
      plain  = 8'(diff * key);
      result = plain;
    end else begin
      plain  = hold_data;
      result = cipher;
    end
  end

  assign chain_key_next = {plain[6:0], 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_data  <= data_byte;
      hold_first <= first_byte;
      hold_last  <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_key <= START_KEY_RESET;
    end else if (advance) begin
      chain_key <= chain_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= result;
      next_key <= chain_key_next;
      out_last <= hold_last;
    end
  end

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid)
    else $error("input stalled with empty hold stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat did not reach result register");

  a_key_odd_after_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> chain_key[0])
    else $error("chained key is even");

  a_result_key_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_key[0])
    else $error("reported next key is even");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !hold_valid |=> !out_valid)
    else $error("result beat repeated");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for the chained byte multiply cipher: directed table, random messages.
module tb_top;
  import cbmc_pkg::*;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_BYTES = 160;
  localparam int NUM_ROWS = 17;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] next_key;
    logic       out_last;
  } cipher_out_t;

  typedef struct packed {
    logic       set_cfg;
    logic       mode;
    logic [7:0] skey;
    logic [7:0] offs;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       pinned;
    logic [7:0] exp_byte;
    logic [7:0] exp_key;
  } script_row_t;

  localparam script_row_t SCRIPT [NUM_ROWS] = '{
    '{1'b0, MODE_ENCRYPT, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 8'h01},
    '{1'b0, MODE_ENCRYPT, 8'h01, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF},
    '{1'b0, MODE_ENCRYPT, 8'h01, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1, 8'h01, 8'h03},
    '{1'b0, MODE_ENCRYPT, 8'h01, 8'h00, 8'hA5, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b1, MODE_DECRYPT, 8'h00, 8'h00, 8'h37, 1'b1, 1'b0, 1'b1, 8'h00, 8'h01},
    '{1'b0, MODE_DECRYPT, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF},
    '{1'b0, MODE_DECRYPT, 8'h00, 8'h00, 8'h80, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b1, MODE_DECRYPT, 8'h80, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, MODE_DECRYPT, 8'h80, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b1, MODE_ENCRYPT, 8'hFE, 8'hFF, 8'h01, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, MODE_ENCRYPT, 8'hFE, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, 8'hFF, 8'h01},
    '{1'b0, MODE_ENCRYPT, 8'hFE, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b1, MODE_ENCRYPT, 8'hFF, 8'h80, 8'h55, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, MODE_ENCRYPT, 8'hFF, 8'h80, 8'hAA, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
    '{1'b0, MODE_ENCRYPT, 8'hFF, 8'h80, 8'h80, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00},
    '{1'b1, MODE_DECRYPT, 8'h01, 8'h80, 8'h80, 1'b1, 1'b0, 1'b1, 8'h00, 8'h01},
    '{1'b0, MODE_DECRYPT, 8'h01, 8'h80, 8'h7F, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        data_byte;
  logic              first_byte;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_byte;
  logic [7:0]        next_key;
  logic              out_last;

  chained_byte_multiply_cipher dut (.*);

  cfg_t          cfg_shadow;
  logic [7:0]    chain_key;
  cipher_out_t   pending_out [$];
  int unsigned   errors = 0;
  int unsigned   burst_left = 0;
  logic          pin_use = 1'b0;
  logic [7:0]    pin_byte = 8'h00;
  logic [7:0]    pin_key = 8'h00;
  logic          hold_go = 1'b0;
  logic          hold_on = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   stall_mode = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] odd_recip(input logic [7:0] k);
    logic [7:0] x;
    x = k;
    repeat (3) x = x * (8'd2 - k * x);
    return x;
  endfunction

  function automatic cipher_out_t cipher_predict(input logic [7:0] data, input logic first,
                                                 input logic last);
    logic [7:0]  key;
    logic [7:0]  plain;
    cipher_out_t r;
    if (first) chain_key = cfg_shadow.start_key;
    key = chain_key;
    if (cfg_shadow.mode_decrypt == MODE_DECRYPT) begin
      plain = (data - cfg_shadow.offset_alpha) * key;
      r.out_byte = plain;
    end else begin
      plain = data;
      r.out_byte = cfg_shadow.offset_alpha + plain * odd_recip(key | 8'd1);
    end
    chain_key = {plain[6:0], 1'b1};
    r.next_key = chain_key;
    r.out_last = last;
    return r;
  endfunction

  always @(posedge clk) begin
    cipher_out_t want;
    cipher_out_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = cipher_predict(data_byte, first_byte, last_byte);
        if (pin_use) begin
          want.out_byte = pin_byte;
          want.next_key = pin_key;
        end
        pending_out.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_byte, next_key, out_last};
        if (pending_out.size() == 0) begin
          if (errors < 10) $display("unexpected beat: byte %h key %h last %b",
                                    got.out_byte, got.next_key, got.out_last);
          errors++;
        end else begin
          want = pending_out.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: byte %h/%h key %h/%h last %b/%b (expected/actual)",
                       want.out_byte, got.out_byte, want.next_key, got.next_key,
                       want.out_last, got.out_last);
            errors++;
          end
        end
      end
    end
  end

  // receiver: windows of varying stall density, overridden by the long hold
  always @(negedge clk) begin
    logic pattern;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end
    stall_left--;
    case (stall_mode)
      0: pattern = 1'b0;
      1: pattern = ($urandom_range(0, 3) == 0);
      2: pattern = 1'($urandom_range(0, 1));
      default: pattern = ($urandom_range(0, 3) != 0);
    endcase
    out_stall = hold_on | pattern;
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (240) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic drain_wait();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE_DECRYPT: cfg_shadow.mode_decrypt = value[0];
      REG_START_KEY:    cfg_shadow.start_key = value[7:0];
      REG_OFFSET_ALPHA: cfg_shadow.offset_alpha = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [7:0] skey, input logic [7:0] offs);
    drain_wait();
    reg_write(REG_MODE_DECRYPT, {31'd0, mode});
    reg_write(REG_START_KEY, {24'd0, skey});
    reg_write(REG_OFFSET_ALPHA, {24'd0, offs});
  endtask

  task automatic send_beat(input logic [7:0] data, input logic first, input logic last,
                           input logic pinned, input logic [7:0] exp_byte,
                           input logic [7:0] exp_key);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    data_byte = data;
    first_byte = first;
    last_byte = last;
    pin_use = pinned;
    pin_byte = exp_byte;
    pin_key = exp_key;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    logic        noise;
    logic        first;
    logic        last;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    data_byte = 8'h00;
    first_byte = 1'b0;
    last_byte = 1'b0;
    out_stall = 1'b0;
    cfg_shadow = '{MODE_DECRYPT_RESET, START_KEY_RESET, OFFSET_ALPHA_RESET};
    chain_key = START_KEY_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (SCRIPT[i].set_cfg) set_config(SCRIPT[i].mode, SCRIPT[i].skey, SCRIPT[i].offs);
      send_beat(SCRIPT[i].data, SCRIPT[i].first, SCRIPT[i].last, SCRIPT[i].pinned,
                SCRIPT[i].exp_byte, SCRIPT[i].exp_key);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(1'($urandom_range(0, 1)), pick_byte(), pick_byte());
      sent = 0;
      while (sent < PHASE_BYTES) begin
        msg_len = $urandom_range(1, 24);
        for (int unsigned b = 0; b < msg_len; b++) begin
          noise = ($urandom_range(0, 9) == 0);
          first = noise ? 1'($urandom_range(0, 1)) : (b == 0);
          last = noise ? 1'($urandom_range(0, 1)) : (b == msg_len - 1);
          send_beat(8'($urandom_range(0, 255)), first, last, 1'b0, 8'h00, 8'h00);
          sent++;
          if (p == 2 && sent == 20) hold_go = 1'b1;
        end
      end
    end

    drain_wait();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/cbmc_pkg.sv
rtl/cbmc_regs.sv
rtl/cbmc_datapath.sv
rtl/chained_byte_multiply_cipher.sv
test/tb_top.sv
